FILE: rtl/assert_macros.svh
// Assertion macros shared by the line editor RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tle_pkg.sv
// Types and constants shared by the terminal line editor modules.
`timescale 1ns / 1ps
package tle_pkg;

  localparam int CNT_W     = 5;
  localparam int CAP_LIMIT = 30;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CANCEL = 8'h03;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_SPACE  = 8'h20;

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_EOL,
    CLS_CANCEL,
    CLS_ERASE,
    CLS_PRINT
  } byte_class_t;

  typedef enum logic [2:0] {
    EM_BYTE,
    EM_CR,
    EM_LF,
    EM_BS,
    EM_SP,
    EM_CHAR,
    EM_END,
    EM_CANCEL
  } emit_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_PUSH,
    CNT_POP
  } cnt_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO,
    ST_BS1,
    ST_BS2,
    ST_BS3,
    ST_CR,
    ST_LF,
    ST_CHAR,
    ST_END,
    ST_CANCEL
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    cnt_op_t   cnt_op;
    logic      ptr_clr;
    logic      rd_en;
  } tle_cmd_t;

  typedef struct packed {
    logic        slot_free;
    byte_class_t cls;
    logic        cnt_zero;
    logic        full;
    logic        ptr_end;
  } tle_sts_t;

endpackage

FILE: rtl/tle_dp.sv
// Line editor datapath: request byte, line store, counters and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tle_dp #(
  parameter int BUFFER_SIZE = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_rx_byte,
  input  tle_pkg::tle_cmd_t       cmd,
  output tle_pkg::tle_sts_t       sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_data_byte,
  output logic [tle_pkg::CNT_W-1:0] out_line_length,
  output logic                    out_last
);

  localparam int CAPACITY = (BUFFER_SIZE - 2 > tle_pkg::CAP_LIMIT) ?
                            tle_pkg::CAP_LIMIT : BUFFER_SIZE - 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = tle_pkg::CNT_W;

  logic [7:0]       mem [CAPACITY];
  logic [7:0]       byte_r;
  logic [7:0]       rd_data_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             last_r, last_nxt;

  tle_pkg::byte_class_t cls;
  logic                 slot_free;

  always_comb begin
    case (byte_r)
      tle_pkg::KEY_NUL:               cls = tle_pkg::CLS_NUL;
      tle_pkg::KEY_CR, tle_pkg::KEY_LF: cls = tle_pkg::CLS_EOL;
      tle_pkg::KEY_CANCEL:            cls = tle_pkg::CLS_CANCEL;
      tle_pkg::KEY_BS, tle_pkg::KEY_DEL: cls = tle_pkg::CLS_ERASE;
      default:                        cls = tle_pkg::CLS_PRINT;
    endcase
  end

  assign slot_free     = !out_valid_r || out_ready;
  assign sts.slot_free = slot_free;
  assign sts.cls       = cls;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.full      = (cnt_r >= CNT_W'(CAPACITY));
  assign sts.ptr_end   = (ptr_r == cnt_r);

  always_comb begin
    case (cmd.cnt_op)
      tle_pkg::CNT_CLEAR: cnt_nxt = '0;
      tle_pkg::CNT_PUSH:  cnt_nxt = cnt_r + CNT_W'(1);
      tle_pkg::CNT_POP:   cnt_nxt = cnt_r - CNT_W'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.rd_en) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  // Result field select
  always_comb begin
    kind_nxt = tle_pkg::KIND_ECHO;
    data_nxt = '0;
    len_nxt  = '0;
    case (cmd.emit_sel)
      tle_pkg::EM_BYTE:   data_nxt = byte_r;
      tle_pkg::EM_CR:     data_nxt = tle_pkg::KEY_CR;
      tle_pkg::EM_LF:     data_nxt = tle_pkg::KEY_LF;
      tle_pkg::EM_BS:     data_nxt = tle_pkg::KEY_BS;
      tle_pkg::EM_SP:     data_nxt = tle_pkg::KEY_SPACE;
      tle_pkg::EM_CHAR: begin
        kind_nxt = tle_pkg::KIND_CHAR;
        data_nxt = rd_data_r;
      end
      tle_pkg::EM_END: begin
        kind_nxt = tle_pkg::KIND_END;
        len_nxt  = cnt_r;
      end
      tle_pkg::EM_CANCEL: kind_nxt = tle_pkg::KIND_CANCEL;
      default:            kind_nxt = tle_pkg::KIND_ECHO;
    endcase
    last_nxt = cmd.emit_last;
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r <= in_rx_byte;
    end
    if (cmd.emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      len_r  <= len_nxt;
      last_r <= last_nxt;
    end
  end

  // Line store: one write port at the count, one registered read port at the pointer
  always_ff @(posedge clk) begin
    if (cmd.cnt_op == tle_pkg::CNT_PUSH) begin
      mem[cnt_r[IDX_W-1:0]] <= byte_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_data_byte   = data_r;
  assign out_line_length = len_r;
  assign out_last        = last_r;

  `ASSERT_ALWAYS(a_cnt_in_range, cnt_r <= CNT_W'(CAPACITY), "char count beyond capacity")
  `ASSERT_IMPLIES(a_emit_slot, cmd.emit, slot_free, "result loaded over a pending one")
  `ASSERT_IMPLIES(a_read_in_line, cmd.rd_en, ptr_r < cnt_r, "read past end of line")
  `ASSERT_NEXT(a_end_clears, cmd.emit && cmd.emit_sel == tle_pkg::EM_END, cnt_r == '0,
               "line end left characters behind")

endmodule

FILE: rtl/tle_ctrl.sv
// Line editor controller: sequences the results of one received byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tle_pkg::tle_sts_t sts,
  output tle_pkg::tle_cmd_t cmd
);

  tle_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tle_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tle_pkg::ST_DECODE;
      end
      tle_pkg::ST_DECODE: begin
        case (sts.cls)
          tle_pkg::CLS_EOL, tle_pkg::CLS_CANCEL: state_nxt = tle_pkg::ST_CR;
          tle_pkg::CLS_ERASE:
            state_nxt = sts.cnt_zero ? tle_pkg::ST_IDLE : tle_pkg::ST_BS1;
          tle_pkg::CLS_PRINT:
            state_nxt = sts.full ? tle_pkg::ST_IDLE : tle_pkg::ST_ECHO;
          default: state_nxt = tle_pkg::ST_IDLE;
        endcase
      end
      tle_pkg::ST_ECHO: if (sts.slot_free) state_nxt = tle_pkg::ST_IDLE;
      tle_pkg::ST_BS1:  if (sts.slot_free) state_nxt = tle_pkg::ST_BS2;
      tle_pkg::ST_BS2:  if (sts.slot_free) state_nxt = tle_pkg::ST_BS3;
      tle_pkg::ST_BS3:  if (sts.slot_free) state_nxt = tle_pkg::ST_IDLE;
      tle_pkg::ST_CR:   if (sts.slot_free) state_nxt = tle_pkg::ST_LF;
      tle_pkg::ST_LF: begin
        if (sts.slot_free) begin
          if (sts.cls == tle_pkg::CLS_CANCEL) begin
            state_nxt = tle_pkg::ST_CANCEL;
          end else if (sts.cnt_zero) begin
            state_nxt = tle_pkg::ST_END;
          end else begin
            state_nxt = tle_pkg::ST_CHAR;
          end
        end
      end
      tle_pkg::ST_CHAR: begin
        if (sts.slot_free && sts.ptr_end) state_nxt = tle_pkg::ST_END;
      end
      tle_pkg::ST_END:    if (sts.slot_free) state_nxt = tle_pkg::ST_IDLE;
      tle_pkg::ST_CANCEL: if (sts.slot_free) state_nxt = tle_pkg::ST_IDLE;
      default:            state_nxt = tle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.emit_sel  = tle_pkg::EM_BYTE;
    cmd.cnt_op    = tle_pkg::CNT_HOLD;
    case (state_r)
      tle_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tle_pkg::ST_DECODE: cmd.ptr_clr = 1'b1;
      tle_pkg::ST_ECHO: begin
        cmd.emit      = sts.slot_free;
        cmd.emit_sel  = tle_pkg::EM_BYTE;
        cmd.emit_last = 1'b1;
        cmd.cnt_op    = sts.slot_free ? tle_pkg::CNT_PUSH : tle_pkg::CNT_HOLD;
      end
      tle_pkg::ST_BS1: begin
        cmd.emit     = sts.slot_free;
        cmd.emit_sel = tle_pkg::EM_BS;
      end
      tle_pkg::ST_BS2: begin
        cmd.emit     = sts.slot_free;
        cmd.emit_sel = tle_pkg::EM_SP;
      end
      tle_pkg::ST_BS3: begin
        cmd.emit      = sts.slot_free;
        cmd.emit_sel  = tle_pkg::EM_BS;
        cmd.emit_last = 1'b1;
        cmd.cnt_op    = sts.slot_free ? tle_pkg::CNT_POP : tle_pkg::CNT_HOLD;
      end
      tle_pkg::ST_CR: begin
        cmd.emit     = sts.slot_free;
        cmd.emit_sel = tle_pkg::EM_CR;
      end
      tle_pkg::ST_LF: begin
        cmd.emit     = sts.slot_free;
        cmd.emit_sel = tle_pkg::EM_LF;
        cmd.rd_en    = sts.slot_free && (sts.cls != tle_pkg::CLS_CANCEL) && !sts.cnt_zero;
      end
      tle_pkg::ST_CHAR: begin
        cmd.emit     = sts.slot_free;
        cmd.emit_sel = tle_pkg::EM_CHAR;
        cmd.rd_en    = sts.slot_free && !sts.ptr_end;
      end
      tle_pkg::ST_END: begin
        cmd.emit      = sts.slot_free;
        cmd.emit_sel  = tle_pkg::EM_END;
        cmd.emit_last = 1'b1;
        cmd.cnt_op    = sts.slot_free ? tle_pkg::CNT_CLEAR : tle_pkg::CNT_HOLD;
      end
      tle_pkg::ST_CANCEL: begin
        cmd.emit      = sts.slot_free;
        cmd.emit_sel  = tle_pkg::EM_CANCEL;
        cmd.emit_last = 1'b1;
        cmd.cnt_op    = sts.slot_free ? tle_pkg::CNT_CLEAR : tle_pkg::CNT_HOLD;
      end
      default: in_ready = 1'b0;
    endcase
  end

  `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
               "new request taken while one is in work")
  `ASSERT_NEXT(a_last_to_idle, cmd.emit && cmd.emit_last, state_r == tle_pkg::ST_IDLE,
               "final result did not end the request")

endmodule

FILE: rtl/terminal_line_editor.sv
// Top level of the terminal line editor: controller plus datapath.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------------------
//   in_     | in  | in_valid / in_ready   | in_rx_byte
//   out_    | out | out_valid / out_ready | out_kind, out_data_byte, out_line_length, out_last
//
// One request is in work at a time; in_ready is high only while the controller idles.
// Results: none for a dropped byte (NUL, erase on empty, byte on full line), the byte on echo,
// BS, SP, BS on erase, CR, LF, cancel on Ctrl-C, CR, LF, each character, end on line end.
// The registered line-store read port paces a line end at one character a cycle if unstalled.
// Reset (rst_n low, synchronous) empties the line and the output register, not the store.
// An out_ready stall freezes the sequencer and keeps in_ready low until the last result loads.
`timescale 1ns / 1ps
module terminal_line_editor #(
  parameter int BUFFER_SIZE = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data_byte,
  output logic [tle_pkg::CNT_W-1:0] out_line_length,
  output logic                      out_last
);

  // Command and status between sequencer and datapath
  tle_pkg::tle_cmd_t cmd;
  tle_pkg::tle_sts_t sts;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath owns the line store; capacity is BUFFER_SIZE-2, capped at 30 characters
  tle_dp #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

endmodule
